FILE: rtl/mads_pkg.sv
package mads_pkg;

  localparam int NUM_MOTORS_DEF    = 8;
  localparam int POSITION_BITS_DEF = 12;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd1000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_DIR   = 2'd2,
    CMD_CAM   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UPDATE_INTERVAL = 2'd0,
    REG_OPEN_ANGLE      = 2'd1,
    REG_CLOSE_ANGLE     = 2'd2
  } reg_index_t;

  // Per-tick context carried down the axis pipeline
  typedef struct packed {
    logic       latch;
    logic [7:0] dirs;
    logic [1:0] manual;
  } tick_ctx_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  axis;
    logic [31:0] speed;
  } stage_wr_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } pipe_status_t;

  typedef struct packed {
    logic [7:0] step_pulses;
    logic [7:0] directions;
    logic       shutter;
    logic       meter;
    logic       speeds_latched;
  } result_t;

  function automatic logic phase_bit(input logic [63:0] a);
    return a[31] ^ a[30];
  endfunction

  // High word of an accumulator rounded onto a whole step on stop.
  // Works on the magnitude; the low word is known nonzero here.
  function automatic logic [31:0] round_hi(input logic [63:0] a, input logic [31:0] prev);
    logic        neg;
    logic        fwd;
    logic [31:0] neg_lo;
    logic [1:0]  quarter;
    logic        inc;
    neg     = a[63];
    fwd     = ~prev[31] ^ neg;
    neg_lo  = 32'd0 - a[31:0];
    quarter = neg ? neg_lo[31:30] : a[31:30];
    inc     = (fwd && quarter != 2'd0) || (!fwd && quarter == 2'd3);
    return (neg ^ inc) ? a[63:32] + 32'd1 : a[63:32];
  endfunction

endpackage

FILE: rtl/mads_if.sv
interface mads_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [3:0]         axis;
  logic signed [31:0] value;

  modport source(output valid, command, axis, value, input ready);
  modport sink(input valid, command, axis, value, output ready);
endinterface

interface mads_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] step_pulses;
  logic [7:0] directions;
  logic       shutter;
  logic       meter;
  logic       speeds_latched;

  modport source(output valid, step_pulses, directions, shutter, meter, speeds_latched,
                 input ready);
  modport sink(input valid, step_pulses, directions, shutter, meter, speeds_latched,
               output ready);
endinterface

FILE: rtl/multi_axis_dda_step_generator.sv
// Channel   Role   Carries
// items     sink   command, axis, value
// results   source step_pulses, directions, shutter, meter, speeds_latched
//
// A tick walks the axis memory one axis a cycle, unless a write hazard holds it,
// over all NUM_MOTORS+1 axes, and its result leaves the accumulate stage after
// the last axis read; the next item is taken once the walk ends, and a
// write item needs no walk. After reset the memories are cleared, one entry
// a cycle, before the first item. Results wait in a two-entry buffer; with
// two ticks unclaimed no further item is taken.
module multi_axis_dda_step_generator
  import mads_pkg::*;
#(
  parameter int NUM_MOTORS    = NUM_MOTORS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mads_in_if.sink                items,
  mads_out_if.source             results
);

  logic [15:0]  update_interval;
  logic [11:0]  open_angle;
  logic [11:0]  close_angle;
  logic [15:0]  tick_count;
  logic [15:0]  tick_inc;
  logic [7:0]   staged_dirs;
  logic [7:0]   applied_dirs;
  logic [1:0]   manual_bits;
  logic [1:0]   outstanding;
  logic         accept;
  logic         accept_tick;
  logic         latch_now;
  logic         res_valid;
  result_t      res;
  tick_ctx_t    ctx;
  stage_wr_t    stage_wr;
  pipe_status_t status;
  cmd_t         cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval <= UPDATE_INTERVAL_RST;
      open_angle      <= '0;
      close_angle     <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_UPDATE_INTERVAL: update_interval <= cfg_data;
        REG_OPEN_ANGLE:      open_angle      <= cfg_data[11:0];
        REG_CLOSE_ANGLE:     close_angle     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign items.ready = !status.clearing && !status.busy && outstanding != 2'd2;
  assign accept      = items.valid && items.ready;
  assign cmd         = cmd_t'(items.command);
  assign accept_tick = accept && cmd == CMD_TICK;
  assign tick_inc    = tick_count + 16'd1;
  assign latch_now   = tick_inc == update_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      staged_dirs  <= '0;
      applied_dirs <= '0;
      manual_bits  <= '0;
    end else if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          tick_count <= latch_now ? 16'd0 : tick_inc;
          if (latch_now) begin
            applied_dirs <= staged_dirs;
          end
        end
        CMD_SPEED: ;
        CMD_DIR:   staged_dirs <= items.value[7:0];
        CMD_CAM:   manual_bits <= items.value[1:0];
      endcase
    end
  end

  // Ticks accepted whose results have not been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else begin
      outstanding <= outstanding + 2'(accept_tick) - 2'(results.valid && results.ready);
    end
  end

  assign ctx.latch  = latch_now;
  assign ctx.dirs   = latch_now ? staged_dirs : applied_dirs;
  assign ctx.manual = manual_bits;

  // Drop a staged speed for an axis beyond the camera
  assign stage_wr.en    = accept && cmd == CMD_SPEED &&
                          32'(items.axis) <= 32'(NUM_MOTORS);
  assign stage_wr.axis  = items.axis;
  assign stage_wr.speed = items.value;

  mads_axis_pipe #(
    .NUM_MOTORS    (NUM_MOTORS),
    .POSITION_BITS (POSITION_BITS)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .start       (accept_tick),
    .start_ctx   (ctx),
    .stage_wr    (stage_wr),
    .open_angle  (open_angle),
    .close_angle (close_angle),
    .status      (status),
    .res_valid   (res_valid),
    .res         (res)
  );

  mads_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .results   (results)
  );

  assert property (@(posedge clk) disable iff (rst) accept_tick |=> status.busy)
    else $error("tick accepted but axis walk did not start");

  assert property (@(posedge clk) disable iff (rst) results.valid |-> outstanding != 2'd0)
    else $error("result offered with no tick outstanding");

  assert property (@(posedge clk) disable iff (rst) res_valid |-> outstanding != 2'd0)
    else $error("result produced with no tick outstanding");

  assert property (@(posedge clk) disable iff (rst) (accept_tick && latch_now) |=>
                   tick_count == 16'd0)
    else $error("tick counter not cleared on latch");

endmodule

FILE: rtl/mads_ram.sv
module mads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mads_axis_pipe.sv
module mads_axis_pipe
  import mads_pkg::*;
#(
  parameter int NUM_MOTORS    = NUM_MOTORS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  tick_ctx_t    start_ctx,
  input  stage_wr_t    stage_wr,
  input  logic [11:0]  open_angle,
  input  logic [11:0]  close_angle,
  output pipe_status_t status,
  output logic         res_valid,
  output result_t      res
);

  localparam int AXES = NUM_MOTORS + 1;
  localparam int AW   = $clog2(AXES);
  localparam int CW   = (POSITION_BITS > 12) ? POSITION_BITS : 12;
  localparam logic [AW-1:0] CAM = AW'(NUM_MOTORS);

  // Clearing pass
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Issue stage
  logic          iss_busy;
  logic [AW-1:0] iss_axis;
  tick_ctx_t     iss_ctx;
  logic          hazard;
  logic          iss_fire;

  // Read stage
  logic          rd_valid;
  logic [AW-1:0] rd_axis;
  tick_ctx_t     rd_ctx;
  logic [95:0]   acc_rdata;
  logic [31:0]   stg_rdata;
  logic [63:0]   rd_acc;
  logic [31:0]   rd_act;
  logic          rd_round;
  logic [31:0]   rd_speed_next;
  logic [63:0]   rd_acc_next;

  // Accumulate stage
  logic          ex_valid;
  logic [AW-1:0] ex_axis;
  tick_ctx_t     ex_ctx;
  logic [63:0]   ex_acc;
  logic [31:0]   ex_speed;
  logic [63:0]   ex_sum;
  logic          ex_pulse;
  logic [7:0]    ex_pulse_mask;
  logic [7:0]    pulse_acc;
  logic [7:0]    pulse_acc_next;
  logic [CW-1:0] cam_pos;
  logic          in_window;
  logic [1:0]    cam_bits;

  // Memory ports
  logic          acc_we;
  logic [AW-1:0] acc_waddr;
  logic [95:0]   acc_wdata;
  logic          stg_we;
  logic [AW-1:0] stg_waddr;
  logic [31:0]   stg_wdata;

  mads_ram #(.WIDTH(96), .DEPTH(AXES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (iss_axis),
    .rdata (acc_rdata)
  );

  mads_ram #(.WIDTH(32), .DEPTH(AXES)) u_stg_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .raddr (iss_axis),
    .rdata (stg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == CAM) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Hold the walk while a later stage still owes a write to the same entry
  assign hazard   = (rd_valid && rd_axis == iss_axis) || (ex_valid && ex_axis == iss_axis);
  assign iss_fire = iss_busy && !hazard;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_busy <= 1'b0;
      iss_axis <= '0;
    end else if (start && !iss_busy) begin
      iss_busy <= 1'b1;
      iss_axis <= '0;
    end else if (iss_fire) begin
      if (iss_axis == CAM) begin
        iss_busy <= 1'b0;
      end else begin
        iss_axis <= iss_axis + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !iss_busy) begin
      iss_ctx <= start_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      ex_valid <= 1'b0;
    end else begin
      rd_valid <= iss_fire;
      ex_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_axis  <= iss_axis;
    rd_ctx   <= iss_ctx;
    ex_axis  <= rd_axis;
    ex_ctx   <= rd_ctx;
    ex_acc   <= rd_acc_next;
    ex_speed <= rd_speed_next;
  end

  // Latch staged speed and round a motor that stops mid-step
  always_comb begin
    rd_acc        = acc_rdata[63:0];
    rd_act        = acc_rdata[95:64];
    rd_speed_next = rd_ctx.latch ? stg_rdata : rd_act;
    rd_round      = rd_ctx.latch && rd_axis != CAM && rd_act != 32'd0 &&
                    stg_rdata == 32'd0 && rd_acc[31:0] != 32'd0 && phase_bit(rd_acc);
    rd_acc_next   = rd_round ? {round_hi(rd_acc, rd_act), 32'd0} : rd_acc;
  end

  always_comb begin
    ex_sum        = ex_acc + {{32{ex_speed[31]}}, ex_speed};
    ex_pulse      = !phase_bit(ex_acc) && phase_bit(ex_sum);
    ex_pulse_mask = (ex_axis != CAM && ex_pulse && 32'(ex_axis) < 32'd8)
                    ? (8'd1 << ex_axis) : 8'd0;
    pulse_acc_next = ((ex_axis == '0) ? 8'd0 : pulse_acc) | ex_pulse_mask;
    cam_pos   = CW'(ex_sum[32 +: POSITION_BITS]);
    in_window = cam_pos >= CW'(open_angle) && cam_pos <= CW'(close_angle);
    cam_bits  = (ex_speed != 32'd0) ? {2{in_window}} : ex_ctx.manual;
  end

  always_ff @(posedge clk) begin
    if (ex_valid) begin
      pulse_acc <= pulse_acc_next;
    end
  end

  always_comb begin
    if (clr_active) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr;
      acc_wdata = '0;
      stg_we    = 1'b1;
      stg_waddr = clr_addr;
      stg_wdata = '0;
    end else begin
      acc_we    = ex_valid;
      acc_waddr = ex_axis;
      acc_wdata = {ex_speed, ex_sum};
      stg_we    = stage_wr.en;
      stg_waddr = AW'(stage_wr.axis);
      stg_wdata = stage_wr.speed;
    end
  end

  assign res_valid          = ex_valid && ex_axis == CAM;
  assign res.step_pulses    = pulse_acc;
  assign res.directions     = ex_ctx.dirs;
  assign res.shutter        = cam_bits[0];
  assign res.meter          = cam_bits[1];
  assign res.speeds_latched = ex_ctx.latch;

  assign status.clearing = clr_active;
  assign status.busy     = iss_busy;

endmodule

FILE: rtl/mads_out_buf.sv
module mads_out_buf
  import mads_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  mads_out_if.source results
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    head;

  assign pop  = results.valid && results.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign results.valid          = count != 2'd0;
  assign results.step_pulses    = head.step_pulses;
  assign results.directions     = head.directions;
  assign results.shutter        = head.shutter;
  assign results.meter          = head.meter;
  assign results.speeds_latched = head.speeds_latched;

endmodule

FILE: tb/tb_multi_axis_dda_step_generator.sv
module tb_multi_axis_dda_step_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mads_pkg::*;

  localparam int AXIS_COUNT  = NUM_MOTORS_DEF + 1;
  localparam int CAM_AXIS    = NUM_MOTORS_DEF;
  localparam int POS_W       = POSITION_BITS_DEF;
  localparam int SETTLE_CYC  = 32;
  localparam int HOLD_CYC    = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  class step_gen_scoreboard;
    logic [63:0]      phase_acc  [AXIS_COUNT];
    logic [31:0]      speed_now  [AXIS_COUNT];
    logic [31:0]      speed_next [AXIS_COUNT];
    logic [7:0]       dir_next;
    logic [7:0]       dir_now;
    logic [1:0]       cam_manual;
    logic [15:0]      tick_cnt;
    logic [15:0]      interval;
    logic [POS_W-1:0] open_pos;
    logic [POS_W-1:0] close_pos;
    result_t          tick_results_q[$];
    int               errors;

    function new();
      foreach (phase_acc[i]) begin
        phase_acc[i]  = '0;
        speed_now[i]  = '0;
        speed_next[i] = '0;
      end
      dir_next   = '0;
      dir_now    = '0;
      cam_manual = '0;
      tick_cnt   = '0;
      interval   = UPDATE_INTERVAL_RST;
      open_pos   = '0;
      close_pos  = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] data);
      case (idx)
        REG_UPDATE_INTERVAL: interval = data;
        REG_OPEN_ANGLE: open_pos = data[POS_W-1:0];
        REG_CLOSE_ANGLE: close_pos = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic step_phase(logic [63:0] a);
      return a[31] ^ a[30];
    endfunction

    // Clear the fraction and round the magnitude onto a whole step
    function logic [63:0] snap_to_step(logic [63:0] a, logic [31:0] prev);
      logic        neg;
      logic        fwd;
      logic [63:0] mag;
      logic [1:0]  quarter;
      neg = a[63];
      fwd = ~prev[31] ^ neg;
      mag = neg ? 64'd0 - a : a;
      quarter = mag[31:30];
      mag = {mag[63:32], 32'd0};
      if ((fwd && quarter != 2'd0) || (!fwd && quarter == 2'd3))
        mag = mag + 64'h1_0000_0000;
      return neg ? 64'd0 - mag : mag;
    endfunction

    function logic [POS_W-1:0] cam_pos();
      return phase_acc[CAM_AXIS][32 +: POS_W];
    endfunction

    function int ticks_to_latch();
      logic [15:0] gap;
      gap = interval - tick_cnt;
      return (gap == 16'd0) ? 65536 : int'(gap);
    endfunction

    function int pending();
      return tick_results_q.size();
    endfunction

    function void apply_item(cmd_t c, logic [3:0] ax, logic [31:0] v);
      result_t          r;
      logic             latch;
      logic             was_on;
      logic [POS_W-1:0] pos;
      logic [1:0]       cam;
      case (c)
        CMD_SPEED: if (ax < AXIS_COUNT) speed_next[ax] = v;
        CMD_DIR: dir_next = v[7:0];
        CMD_CAM: cam_manual = v[1:0];
        default: begin
          r = '0;
          tick_cnt = tick_cnt + 16'd1;
          latch = (tick_cnt == interval);
          if (latch) begin
            tick_cnt = '0;
            speed_now[CAM_AXIS] = speed_next[CAM_AXIS];
            dir_now = dir_next;
            for (int i = 0; i < NUM_MOTORS_DEF; i++) begin
              if (speed_now[i] != '0 && speed_next[i] == '0 &&
                  phase_acc[i][31:0] != '0 && step_phase(phase_acc[i]))
                phase_acc[i] = snap_to_step(phase_acc[i], speed_now[i]);
              speed_now[i] = speed_next[i];
            end
          end
          for (int i = 0; i < NUM_MOTORS_DEF; i++) begin
            was_on = step_phase(phase_acc[i]);
            phase_acc[i] = phase_acc[i] + {{32{speed_now[i][31]}}, speed_now[i]};
            if (!was_on && step_phase(phase_acc[i]) && i < 8)
              r.step_pulses[i] = 1'b1;
          end
          if (speed_now[CAM_AXIS] != '0) begin
            phase_acc[CAM_AXIS] = phase_acc[CAM_AXIS] +
                                  {{32{speed_now[CAM_AXIS][31]}}, speed_now[CAM_AXIS]};
            pos = cam_pos();
            cam = (pos >= open_pos && pos <= close_pos) ? 2'b11 : 2'b00;
          end else begin
            cam = cam_manual;
          end
          r.directions     = dir_now;
          r.shutter        = cam[0];
          r.meter          = cam[1];
          r.speeds_latched = latch;
          tick_results_q.push_back(r);
        end
      endcase
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, seen);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (tick_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no tick pending, expected none, actual %p", $time, got);
        return;
      end
      want = tick_results_q.pop_front();
      compare_field("step_pulses", want.step_pulses, got.step_pulses);
      compare_field("directions", want.directions, got.directions);
      compare_field("shutter", want.shutter, got.shutter);
      compare_field("meter", want.meter, got.meter);
      compare_field("speeds_latched", want.speeds_latched, got.speeds_latched);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  bit                     idle_on = 1'b1;
  bit                     hold_req = 1'b0;
  int                     cycle_cnt = 0;

  step_gen_scoreboard sb = new();

  mads_in_if  item_ch();
  mads_out_if result_ch();

  multi_axis_dda_step_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch.sink),
    .results   (result_ch.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.apply_item(cmd_t'(item_ch.command), item_ch.axis, item_ch.value);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_t'{step_pulses: result_ch.step_pulses,
                                  directions: result_ch.directions,
                                  shutter: result_ch.shutter,
                                  meter: result_ch.meter,
                                  speeds_latched: result_ch.speeds_latched});
    end
  end

  initial begin : result_sink
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input cmd_t c, input logic [3:0] ax, input logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= c;
    item_ch.axis    <= ax;
    item_ch.value   <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Drop valid, drain every tick result, then let write items finish
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Make the next tick latch so the interval counter restarts from zero
  task automatic realign_counter();
    write_reg(REG_UPDATE_INTERVAL, sb.tick_cnt + 16'd1);
    send_item(CMD_TICK, 4'($urandom), $urandom);
    settle();
  endtask

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'd0 - 32'($urandom_range(1, 3));
      6: return 32'h4000_0000 + 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int         sel;
    logic [3:0] ax;
    sel = $urandom_range(0, 99);
    ax = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (sel < 55)
      send_item(CMD_TICK, 4'($urandom), $urandom);
    else if (sel < 83)
      send_item(CMD_SPEED, ax, pick_speed());
    else if (sel < 91)
      send_item(CMD_DIR, 4'($urandom), $urandom);
    else
      send_item(CMD_CAM, 4'($urandom), $urandom);
  endtask

  task automatic run_directed();
    // reset settings: interval far away, no latch, all outputs low
    send_item(CMD_TICK, 4'd0, 32'd0);
    send_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF);
    settle();
    realign_counter();
    write_reg(REG_UPDATE_INTERVAL, 16'd1);
    write_reg(REG_OPEN_ANGLE, 16'h0000);
    write_reg(REG_CLOSE_ANGLE, 16'hFFFF);
    send_item(CMD_SPEED, 4'd0, 32'h7FFF_FFFF);
    send_item(CMD_SPEED, 4'd1, 32'h8000_0000);
    send_item(CMD_SPEED, 4'd2, 32'h5000_0000);
    send_item(CMD_SPEED, 4'd3, 32'hB000_0000);
    send_item(CMD_SPEED, 4'd8, 32'h4000_0000);
    send_item(CMD_SPEED, 4'd9, 32'h1234_5678);
    send_item(CMD_SPEED, 4'd15, 32'hFFFF_FFFF);
    send_item(CMD_DIR, 4'd0, 32'hFFFF_FF5A);
    send_item(CMD_CAM, 4'd0, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 4'd0, 32'd0);
    send_item(CMD_TICK, 4'd0, 32'd0);
    // stop mid-step in both directions; camera falls back to manual bits
    send_item(CMD_SPEED, 4'd0, 32'd0);
    send_item(CMD_SPEED, 4'd2, 32'd0);
    send_item(CMD_SPEED, 4'd3, 32'd0);
    send_item(CMD_SPEED, 4'd8, 32'd0);
    send_item(CMD_CAM, 4'd0, 32'h0000_0002);
    send_item(CMD_TICK, 4'd0, 32'd0);
    send_item(CMD_TICK, 4'd0, 32'd0);
    settle();
    write_reg(REG_UPDATE_INTERVAL, 16'd3);
    send_item(CMD_TICK, 4'd0, 32'd0);
    send_item(CMD_TICK, 4'd0, 32'd0);
    settle();
    // interval now below the count: the counter must wrap before latching
    write_reg(REG_UPDATE_INTERVAL, 16'd1);
    send_item(CMD_TICK, 4'd0, 32'd0);
    settle();
    realign_counter();
  endtask

  task automatic run_phase(input int idx);
    logic [15:0]      iv;
    logic [15:0]      rnd;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    int               sel;
    pos = sb.cam_pos();
    rnd = 16'($urandom);
    sel = $urandom_range(0, 19);
    if (idx == 5)
      iv = 16'd0;
    else if (idx == 7)
      iv = 16'hFFFF;
    else if (idx == 9)
      iv = rnd;
    else if (sel < 15)
      iv = 16'($urandom_range(1, 8));
    else
      iv = 16'($urandom_range(9, 64));
    case (idx % 5)
      0: begin
        lo = (idx % 2 != 0) ? {POS_W{1'b1}} : '0;
        hi = ~lo;
      end
      1: begin
        lo = POS_W'($urandom);
        hi = POS_W'($urandom);
      end
      2: begin
        lo = pos;
        hi = pos;
      end
      3: begin
        lo = pos + POS_W'(8);
        hi = pos - POS_W'(8);
      end
      default: begin
        lo = pos - POS_W'($urandom_range(0, 16));
        hi = pos + POS_W'($urandom_range(0, 48));
      end
    endcase
    write_reg(REG_UPDATE_INTERVAL, iv);
    write_reg(REG_OPEN_ANGLE, {rnd[15:12], lo});
    write_reg(REG_CLOSE_ANGLE, {~rnd[15:12], hi});
    if (idx == 3)
      hold_req = 1'b1;
    repeat ($urandom_range(70, 110)) send_random();
    settle();
    if (sb.ticks_to_latch() > 64)
      realign_counter();
  endtask

  initial begin : stimulus
    item_ch.valid   <= 1'b0;
    item_ch.command <= CMD_TICK;
    item_ch.axis    <= '0;
    item_ch.value   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYC) @(posedge clk);
    run_directed();
    for (int p = 0; p < 12; p++) begin
      idle_on = (p < 10);
      run_phase(p);
    end
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/mads_pkg.sv
rtl/mads_if.sv
rtl/mads_ram.sv
rtl/mads_axis_pipe.sv
rtl/mads_out_buf.sv
rtl/multi_axis_dda_step_generator.sv
tb/tb_multi_axis_dda_step_generator.sv
